// ===== rtl/rrp_pkg.sv =====
// Shared types and constants for the rectangle raster painter.
`timescale 1ns / 1ps

package rrp_pkg;

  // Operation codes carried in the opcode field; the fourth code is a no-op.
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_DRAW  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REJECTED = 2'd1;
  localparam logic [1:0] ST_OUTSIDE  = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_BG     = 2'd2;

  localparam logic [7:0] KIND_OUTLINE = 8'h72;
  localparam logic [7:0] KIND_FILLED  = 8'h52;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP1,
    S_SETUP2,
    S_SCAN,
    S_READ,
    S_DONE
  } rrp_state_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic [7:0]         shape_kind;
    logic signed [19:0] rect_left;
    logic signed [19:0] rect_top;
    logic signed [19:0] rect_width;
    logic signed [19:0] rect_height;
    logic [7:0]         paint_char;
    logic [7:0]         read_col;
    logic [7:0]         read_row;
  } rrp_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] pixel_value;
  } rrp_result_t;

  typedef struct packed {
    logic [8:0] width;
    logic [8:0] height;
    logic [7:0] bg;
  } rrp_cfg_t;

  typedef struct packed {
    logic load;
    logic setup1;
    logic setup2;
    logic scan;
    logic mem_rd;
  } rrp_cmd_t;

  typedef struct packed {
    logic rect_bad;
    logic scan_last;
  } rrp_stat_t;

endpackage

// ===== rtl/rrp_ctrl.sv =====
// Sequencing state machine of the rectangle raster painter.
`timescale 1ns / 1ps

module rrp_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [1:0]       opcode_i,
  input  rrp_pkg::rrp_stat_t stat_i,
  output rrp_pkg::rrp_cmd_t  cmd_o,
  output logic             busy_o,
  output logic             done_o
);
  import rrp_pkg::*;

  rrp_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    done_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          case (opcode_i)
            OP_CLEAR: state_d = S_SCAN;
            OP_DRAW:  state_d = S_SETUP1;
            OP_READ:  state_d = S_READ;
            default:  state_d = S_DONE;
          endcase
        end
      end
      S_SETUP1: begin
        if (stat_i.rect_bad) begin
          state_d = S_DONE;
        end else begin
          cmd_o.setup1 = 1'b1;
          state_d      = S_SETUP2;
        end
      end
      S_SETUP2: begin
        cmd_o.setup2 = 1'b1;
        state_d      = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_DONE;
        end
      end
      S_READ: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

// ===== rtl/rrp_datapath.sv =====
// Pixel scan counters, rectangle classification and the frame store.
`timescale 1ns / 1ps

module rrp_datapath #(
  parameter int MAX_SIDE = 256
) (
  input  logic                 clk_i,
  input  rrp_pkg::rrp_cfg_t    cfg_i,
  input  rrp_pkg::rrp_item_t   item_i,
  input  rrp_pkg::rrp_cmd_t    cmd_i,
  output rrp_pkg::rrp_stat_t   stat_o,
  output rrp_pkg::rrp_result_t result_o
);
  import rrp_pkg::*;

  localparam int CW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
  localparam int Depth = MAX_SIDE * MAX_SIDE;
  localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int SW    = (CW > 9) ? CW : 9;
  localparam int GW    = (CW + 9 > 22) ? CW + 9 : 22;

  rrp_item_t item_q;
  logic [CW-1:0] col_q, row_q;
  logic signed [GW-1:0] r_q, b_q, l1_q, t1_q, rm_q, bm_q;
  logic signed [GW-1:0] l, t, w, h, x, y;
  logic [7:0] mem_q [Depth];
  logic [7:0] rd_q;
  logic [AW-1:0] waddr, raddr;
  logic col_last, row_last, covered, border, filled, we, outside_rd;
  logic [7:0] wdata;

  assign l = {{(GW-20){item_q.rect_left[19]}}, item_q.rect_left};
  assign t = {{(GW-20){item_q.rect_top[19]}}, item_q.rect_top};
  assign w = {{(GW-20){item_q.rect_width[19]}}, item_q.rect_width};
  assign h = {{(GW-20){item_q.rect_height[19]}}, item_q.rect_height};
  assign x = {{(GW-CW-8){1'b0}}, col_q, 8'h00};
  assign y = {{(GW-CW-8){1'b0}}, row_q, 8'h00};

  assign filled = (item_q.shape_kind == KIND_FILLED);
  assign stat_o.rect_bad =
      ((item_q.shape_kind != KIND_OUTLINE) && !filled) ||
      item_q.rect_width[19] || (item_q.rect_width == '0) ||
      item_q.rect_height[19] || (item_q.rect_height == '0);

  assign col_last = (SW'(col_q) == SW'(cfg_i.width - 9'd1));
  assign row_last = (SW'(row_q) == SW'(cfg_i.height - 9'd1));
  assign stat_o.scan_last = col_last && row_last;

  // Thresholds are prepared ahead of the scan so that each pixel needs only
  // parallel compares: left border is x < l + 256, right border is x > r - 256.
  assign covered = (x >= l) && (x <= r_q) && (y >= t) && (y <= b_q);
  assign border  = (x < l1_q) || (x > rm_q) || (y < t1_q) || (y > bm_q);

  assign we    = cmd_i.scan && ((item_q.opcode == OP_CLEAR) ||
                                (covered && (border || filled)));
  assign wdata = (item_q.opcode == OP_CLEAR) ? cfg_i.bg : item_q.paint_char;
  assign waddr = AW'(AW'(row_q) * AW'(MAX_SIDE) + AW'(col_q));
  assign raddr = AW'(AW'(item_q.read_row) * AW'(MAX_SIDE) + AW'(item_q.read_col));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
      col_q  <= '0;
      row_q  <= '0;
    end else if (cmd_i.scan) begin
      if (col_last) begin
        col_q <= '0;
        row_q <= row_q + CW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
    if (cmd_i.setup1) begin
      r_q  <= l + w;
      b_q  <= t + h;
      l1_q <= l + GW'(256);
      t1_q <= t + GW'(256);
    end
    if (cmd_i.setup2) begin
      rm_q <= r_q - GW'(256);
      bm_q <= b_q - GW'(256);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.mem_rd) begin
      rd_q <= mem_q[raddr];
    end
  end

  assign outside_rd = ({1'b0, item_q.read_col} >= cfg_i.width) ||
                      ({1'b0, item_q.read_row} >= cfg_i.height);

  always_comb begin
    result_o = '0;
    case (item_q.opcode)
      OP_DRAW: begin
        if (stat_o.rect_bad) begin
          result_o.status = ST_REJECTED;
        end
      end
      OP_READ: begin
        if (outside_rd) begin
          result_o.status = ST_OUTSIDE;
        end else begin
          result_o.pixel_value = rd_q;
        end
      end
      default: result_o = '0;
    endcase
  end

endmodule

// ===== rtl/rectangle_raster_painter.sv =====
// Top level of the rectangle raster painter: register port and unit wiring.
//
// A command word is taken on item_i when start is high and busy is low; busy
// then stays high until the command is finished. Each command gives exactly
// one result word on result_o, shown for one cycle with done_o high; the
// receiver cannot hold it off, so it must take the word in that cycle.
// Opcode clear writes the background byte to every canvas pixel; draw
// classifies every canvas pixel against the rectangle and paints the covered
// ones (only the border of an outline); read returns one stored pixel.
// Reads are meaningful only after a clear. After the accepting edge, clear
// runs the scan states and then done; draw runs setup1, setup2, scan, done;
// a rejected draw goes from setup1 to done; read runs read and done; an
// unused opcode goes to done. The frame store has a single write port, so
// clear and draw visit one pixel per cycle, on a canvas of up to 256 by 256.
// The APB port sets canvas width, height and background byte at byte
// addresses 0, 4 and 8; write it only while busy is low. Reset returns the
// canvas to full size and the background to a space, and leaves the frame
// store contents undefined.
`timescale 1ns / 1ps

module rectangle_raster_painter #(
  parameter int MAX_SIDE = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  rrp_pkg::rrp_item_t   item_i,
  output logic                 done_o,
  output rrp_pkg::rrp_result_t result_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import rrp_pkg::*;

  localparam logic [8:0] SideReset = (MAX_SIDE < 256) ? 9'(MAX_SIDE) : 9'd256;

  rrp_cfg_t  cfg_q;
  rrp_cmd_t  cmd;
  rrp_stat_t stat;
  logic      cfg_wr;

  function automatic logic [8:0] clamp_side(input logic [8:0] v);
    logic [8:0] s;
    s = v;
    if (s == 9'd0) begin
      s = 9'd1;
    end else if (int'(s) > MAX_SIDE) begin
      s = 9'(MAX_SIDE);
    end
    return s;
  endfunction

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= SideReset;
      cfg_q.height <= SideReset;
      cfg_q.bg     <= 8'd32;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_WIDTH:  cfg_q.width  <= clamp_side(pwdata[8:0]);
        REG_HEIGHT: cfg_q.height <= clamp_side(pwdata[8:0]);
        REG_BG:     cfg_q.bg     <= pwdata[7:0];
        default:    cfg_q        <= cfg_q;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WIDTH:  prdata = {23'd0, cfg_q.width};
      REG_HEIGHT: prdata = {23'd0, cfg_q.height};
      REG_BG:     prdata = {24'd0, cfg_q.bg};
      default:    prdata = 32'd0;
    endcase
  end

  rrp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .opcode_i (item_i.opcode),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  rrp_datapath #(
    .MAX_SIDE (MAX_SIDE)
  ) u_datapath (
    .clk_i    (clk_i),
    .cfg_i    (cfg_q),
    .item_i   (item_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .result_o (result_o)
  );

`ifndef SYNTHESIS
  a_accept_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted word did not make the block busy");

  a_done_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result word shown while idle");

  a_idle_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!busy && !done_o))
    else $error("block did not return to idle after a result word");

  a_error_no_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.status != ST_OK)) |-> (result_o.pixel_value == 8'd0))
    else $error("failed command returned a nonzero pixel");
`endif

endmodule
